// ----- rtl/cnfsa_pkg.sv -----
// Shared types and constants for the circular next-free-slot allocator.
// Holds the field widths and the controller/datapath command and status structs.
// No dependencies.
package cnfsa_pkg;

    localparam int FIELD_W = 11;
    localparam int TDATA_W = 16;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic clear;
        logic capture;
        logic check;
        logic seed;
        logic use_succ;
        logic walk;
        logic comp;
        logic save_grant;
        logic link;
        logic result;
    } cnfsa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic req_bad;
        logic table_full;
        logic at_root;
        logic comp_done;
        logic more_after;
        logic out_free;
    } cnfsa_status_t;

endpackage

// ----- rtl/circular_next_free_slot_allocator.sv -----
// Top level of the circular next-free-slot allocator.
// Joins cnfsa_ctrl and cnfsa_datapath; uses cnfsa_pkg.
//
// Slots 1 to slot_count are handed out one per request: the grant is the first
// free slot at or after the requested one, wrapping to slot 1. After reset and
// after every slot_count write the parent table is initialised, and no request
// is accepted while that runs. A request is taken only when the block is idle.
// A bad or full request goes from the check state straight to the result. A
// grant walks the parent memory twice per lookup, one entry per cycle over its
// single read port. A grant performs one lookup for the preferred slot and,
// unless the table has just become full, a second for the successor slot.
// Path compression keeps the chains short.
module circular_next_free_slot_allocator import cnfsa_pkg::*; #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [FIELD_W-1:0]  cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // [10:0] requested_slot
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata,   // [10:0] assigned_slot
    output logic [TUSER_W-1:0]  m_axis_tuser    // [0] all_full, [1] bad_request
);

    cnfsa_cmd_t    cmd;
    cnfsa_status_t status;

    cnfsa_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    cnfsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ----- rtl/cnfsa_datapath.sv -----
// Datapath of the slot allocator: parent table memory, walk registers, counters
// and the result register. Driven by cnfsa_ctrl through cnfsa_pkg command/status.
module cnfsa_datapath import cnfsa_pkg::*; #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [FIELD_W-1:0]  cfg_wdata,
    input  logic [TDATA_W-1:0]  s_axis_tdata,
    input  logic                m_axis_tready,
    output logic                m_axis_tvalid,
    output logic [TDATA_W-1:0]  m_axis_tdata,
    output logic [TUSER_W-1:0]  m_axis_tuser,
    input  cnfsa_cmd_t          cmd,
    output cnfsa_status_t       status
);

    localparam int IW = $clog2(MAX_SLOTS + 1);
    localparam int W  = (IW > FIELD_W) ? IW : FIELD_W;

    logic [IW-1:0]      mem [0:MAX_SLOTS];
    logic [IW-1:0]      rd_data_reg;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [IW-1:0]      wr_data;

    logic [IW-1:0]      slot_count_reg;
    logic [IW-1:0]      slot_count_next;
    logic [IW-1:0]      taken_reg;
    logic [IW-1:0]      clr_reg;
    logic [FIELD_W-1:0] req_reg;
    logic [IW-1:0]      node_reg;
    logic [IW-1:0]      root_reg;
    logic [IW-1:0]      granted_reg;
    logic               bad_reg;
    logic               full_reg;

    logic               m_valid_reg;
    logic [FIELD_W-1:0] m_slot_reg;
    logic               m_full_reg;
    logic               m_bad_reg;

    logic [W-1:0]       req_w;
    logic [W-1:0]       cfg_w;
    logic [W-1:0]       granted_w;
    logic [IW:0]        succ_wide;
    logic [IW-1:0]      succ;
    logic [IW-1:0]      start;
    logic               req_bad;
    logic               table_full;

    assign req_w     = W'(req_reg);
    assign cfg_w     = W'(cfg_wdata);
    assign granted_w = W'(granted_reg);

    always_comb begin
        if (cfg_wdata == '0) begin
            slot_count_next = IW'(1);
        end else if (cfg_w > W'(MAX_SLOTS)) begin
            slot_count_next = IW'(MAX_SLOTS);
        end else begin
            slot_count_next = cfg_w[IW-1:0];
        end
    end

    assign succ_wide = {1'b0, granted_reg} + (IW+1)'(1);
    assign succ      = (succ_wide > {1'b0, slot_count_reg}) ? IW'(1) : succ_wide[IW-1:0];
    assign start     = cmd.use_succ ? succ : req_w[IW-1:0];

    assign req_bad    = (req_reg == '0) || (req_w > W'(slot_count_reg));
    assign table_full = (taken_reg >= slot_count_reg);

    assign status.clear_done = (clr_reg == slot_count_reg);
    assign status.req_bad    = req_bad;
    assign status.table_full = table_full;
    assign status.at_root    = (rd_data_reg == node_reg);
    assign status.comp_done  = (node_reg == root_reg);
    assign status.more_after = (({1'b0, taken_reg} + (IW+1)'(1)) < {1'b0, slot_count_reg});
    assign status.out_free   = !m_valid_reg || m_axis_tready;

    always_comb begin
        rd_addr = cmd.seed ? start : rd_data_reg;
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = clr_reg;
        if (cmd.clear) begin
            wr_en = 1'b1;
        end else if (cmd.link) begin
            wr_en   = 1'b1;
            wr_addr = granted_reg;
            wr_data = root_reg;
        end else if (cmd.comp && (node_reg != root_reg)) begin
            wr_en   = 1'b1;
            wr_addr = node_reg;
            wr_data = root_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= IW'(MAX_SLOTS);
            taken_reg      <= '0;
            clr_reg        <= '0;
        end else if (cfg_wen) begin
            slot_count_reg <= slot_count_next;
            taken_reg      <= '0;
            clr_reg        <= '0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (cmd.save_grant) begin
                taken_reg <= taken_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_axis_tdata[FIELD_W-1:0];
        end
        if (cmd.check) begin
            bad_reg  <= req_bad;
            full_reg <= table_full && !req_bad;
        end
        if (cmd.seed) begin
            node_reg <= start;
        end else if (cmd.walk || (cmd.comp && (node_reg != root_reg))) begin
            node_reg <= rd_data_reg;
        end
        if (cmd.walk && (rd_data_reg == node_reg)) begin
            root_reg <= node_reg;
        end
        if (cmd.save_grant) begin
            granted_reg <= root_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            m_slot_reg <= (bad_reg || full_reg) ? '0 : granted_w[FIELD_W-1:0];
            m_full_reg <= full_reg;
            m_bad_reg  <= bad_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_W'(m_slot_reg);
    assign m_axis_tuser  = {m_bad_reg, m_full_reg};

endmodule

// ----- rtl/cnfsa_ctrl.sv -----
// Controller state machine of the slot allocator: table initialisation, the
// find and compression walks, the successor link and result hand-off. Uses cnfsa_pkg.
module cnfsa_ctrl import cnfsa_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wen,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  cnfsa_status_t status,
    output cnfsa_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_CHECK     = 3'd2;
    localparam logic [2:0] ST_SEED      = 3'd3;
    localparam logic [2:0] ST_WALK      = 3'd4;
    localparam logic [2:0] ST_COMP_SEED = 3'd5;
    localparam logic [2:0] ST_COMP      = 3'd6;
    localparam logic [2:0] ST_RESULT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       phase_reg;
    logic       phase_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                cmd.seed  = 1'b1;
                if (status.req_bad || status.table_full) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_SEED: begin
                cmd.seed     = 1'b1;
                cmd.use_succ = 1'b1;
                state_next   = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.at_root) begin
                    state_next = ST_COMP_SEED;
                end
            end
            ST_COMP_SEED: begin
                cmd.seed     = 1'b1;
                cmd.use_succ = phase_reg;
                state_next   = ST_COMP;
            end
            ST_COMP: begin
                cmd.comp = 1'b1;
                if (status.comp_done) begin
                    if (phase_reg) begin
                        cmd.link   = 1'b1;
                        state_next = ST_RESULT;
                    end else begin
                        cmd.save_grant = 1'b1;
                        if (status.more_after) begin
                            phase_next = 1'b1;
                            state_next = ST_SEED;
                        end else begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_wen) begin
            cmd        = '0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circular_next_free_slot_allocator: a predictor with its own
// parent table checks every grant, full reply and rejected request across slot-count settings.
// Depends on cnfsa_pkg and the allocator RTL only.
module tb_top import cnfsa_pkg::*;;

    localparam int MAX_SLOTS   = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] slot;
        logic               all_full;
        logic               bad_request;
    } slot_grant_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wen = 1'b0;
    logic [FIELD_W-1:0] cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // [10:0] requested_slot
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [10:0] assigned_slot
    logic [TUSER_W-1:0] m_axis_tuser;        // [0] all_full, [1] bad_request

    circular_next_free_slot_allocator #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state.
    logic [FIELD_W-1:0] model_parent [0:MAX_SLOTS];
    int                 model_taken;
    int                 model_count;

    logic [FIELD_W-1:0] request_fifo [$];
    slot_grant_t        grants_due [$];
    int                 items_queued = 0;
    int                 grants_done = 0;
    int                 fault_count = 0;
    int                 grant_total = 0;
    int                 full_total = 0;
    int                 reject_total = 0;
    int                 setting_total = 1;
    longint             cycle_count = 0;
    logic               req_taken = 1'b0;

    function automatic int clip_slot(input int v);
        return (v > MAX_SLOTS) ? 0 : v;
    endfunction

    function automatic int clip_count(input int v);
        if (v < 1) return 1;
        if (v > MAX_SLOTS) return MAX_SLOTS;
        return v;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i <= MAX_SLOTS; i++) model_parent[i] = FIELD_W'(i);
        model_taken = 0;
    endfunction

    function automatic int find_free(input int start);
        int node;
        int root;
        int nxt;
        int steps;
        node = clip_slot(start);
        steps = 0;
        while (model_parent[node] != node && steps <= MAX_SLOTS) begin
            node = clip_slot(model_parent[node]);
            steps++;
        end
        root = node;
        node = clip_slot(start);
        steps = 0;
        while (node != root && steps <= MAX_SLOTS) begin
            nxt = clip_slot(model_parent[node]);
            model_parent[node] = FIELD_W'(root);
            node = nxt;
            steps++;
        end
        return root;
    endfunction

    function automatic slot_grant_t predict_grant(input logic [FIELD_W-1:0] req);
        slot_grant_t g;
        int granted;
        int succ;
        int succ_root;
        g = '0;
        if (req == 0 || int'(req) > model_count) begin
            g.bad_request = 1'b1;
        end else if (model_taken >= model_count) begin
            g.all_full = 1'b1;
        end else begin
            granted = find_free(int'(req));
            succ = granted + 1;
            if (succ > model_count) succ = 1;
            model_taken++;
            if (model_taken < model_count) begin
                succ_root = find_free(succ);
                model_parent[clip_slot(granted)] = FIELD_W'(succ_root);
            end
            g.slot = FIELD_W'(granted);
        end
        return g;
    endfunction

    // Monitor and scoreboard.
    always @(posedge aclk) begin
        slot_grant_t want;
        slot_grant_t got;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, grants_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (!aresetn) begin
            model_count = MAX_SLOTS;
            clear_table();
            req_taken = 1'b0;
        end else begin
            if (cfg_wen) begin
                model_count = clip_count(int'(cfg_wdata));
                clear_table();
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot        = m_axis_tdata[FIELD_W-1:0];
                got.all_full    = m_axis_tuser[0];
                got.bad_request = m_axis_tuser[1];
                if (grants_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("Unexpected result: slot %0d full %b bad %b",
                                 got.slot, got.all_full, got.bad_request);
                end else begin
                    want = grants_due.pop_front();
                    grants_done++;
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display({"Mismatch: expected slot %0d full %b bad %b,",
                                      " got slot %0d full %b bad %b"},
                                     want.slot, want.all_full, want.bad_request,
                                     got.slot, got.all_full, got.bad_request);
                    end
                end
            end
            req_taken = s_axis_tvalid && s_axis_tready;
            if (req_taken) begin
                want = predict_grant(s_axis_tdata[FIELD_W-1:0]);
                if (want.bad_request) reject_total++;
                else if (want.all_full) full_total++;
                else grant_total++;
                grants_due.push_back(want);
            end
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (!s_axis_tvalid || req_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (request_fifo.size() > 0) begin
                s_axis_tdata <= {{(TDATA_W-FIELD_W){1'b0}}, request_fifo.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: its stall pattern switches at random among three modes.
    int rx_mode = 0;
    int rx_ticks = 0;
    int stall_left = 0;

    always @(negedge aclk) begin
        rx_ticks <= rx_ticks + 1;
        if (rx_ticks % 256 == 255) rx_mode <= $urandom_range(0, 2);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left <= $urandom_range(1, 20);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic queue_request(input int slot);
        request_fifo.push_back(FIELD_W'(slot));
        items_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (grants_done != items_queued);
    endtask

    task automatic write_slot_count(input int value);
        wait_idle();
        cfg_wdata <= FIELD_W'(value);
        cfg_wen <= 1'b1;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        setting_total++;
    endtask

    function automatic int random_request(input int count);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return $urandom_range(1, count);
        if (pick < 90) return 0;
        if (pick < 95) return $urandom_range(count + 1, (1 << FIELD_W) - 1);
        return $urandom_range(0, (1 << FIELD_W) - 1);
    endfunction

    int phase_value [12] = '{1024, 5, 64, 2, 300, 0, 17, 2047, 128, 1025, 33, 8};
    int phase_items [12] = '{150, 30, 150, 20, 140, 15, 60, 120, 160, 40, 60, 30};

    initial begin
        int count;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset slot count, including wrap and rejections.
        queue_request(1);
        queue_request(1);
        queue_request(1024);
        queue_request(1024);
        queue_request(0);
        queue_request(1025);
        queue_request(2047);
        queue_request(1365);
        queue_request(682);
        queue_request(1023);
        queue_request(1023);

        // A single slot: one grant, then the table is full.
        write_slot_count(1);
        queue_request(1);
        queue_request(1);
        queue_request(2);
        queue_request(0);

        // A written count of zero behaves as one slot.
        write_slot_count(0);
        queue_request(1);
        queue_request(1);

        write_slot_count(2);
        queue_request(2);
        queue_request(2);
        queue_request(1);
        queue_request(1);
        queue_request(3);

        for (int p = 0; p < 12; p++) begin
            write_slot_count(phase_value[p]);
            count = clip_count(phase_value[p]);
            for (int i = 0; i < phase_items[p]; i++) queue_request(random_request(count));
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("Ran %0d requests over %0d slot-count settings: %0d grants, %0d full replies,",
                 items_queued, setting_total, grant_total, full_total);
        $display("%0d rejected requests, %0d faults.", reject_total, fault_count);
        if (fault_count == 0 && grants_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
